@@ rtl/core/keq_pkg.sv @@
// keq_pkg: shared types and constants of the key and encoder qualifier.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package keq_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_PRESS_SCANS    = 3'd0,
      CSR_REPEAT_SCANS   = 3'd1,
      CSR_ENC_LOW_LIMIT  = 3'd2,
      CSR_ENC_HIGH_LIMIT = 3'd3,
      CSR_ENC_CENTER     = 3'd4
   } csr_index_type;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 8;

   // reset values of the configuration registers
   localparam logic [7:0] PressScansReset   = 8'd6;
   localparam logic [7:0] RepeatScansReset  = 8'd20;
   localparam logic [7:0] EncLowLimitReset  = 8'd5;
   localparam logic [7:0] EncHighLimitReset = 8'd195;
   localparam logic [7:0] EncCenterReset    = 8'd100;

   // item kinds
   localparam logic FuncCapture = 1'b0;
   localparam logic FuncPoll    = 1'b1;

   // encoder direction codes
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } enc_dir_type;

   localparam logic [3:0] KeysReleased = 4'hf;
   localparam logic [5:0] SecMinLast   = 6'd59;

   // decision of the encoder stage for one item
   typedef struct packed {
      enc_dir_type dir;
      logic [7:0]  steps;
      logic        reload;
      logic        scan;      // poll runs a key scan this item
      logic        enc_act;   // encoder report clears the idle timer
   } enc_res_type;

   // idle timer control from the scan path
   typedef struct packed {
      logic clear;            // input activity seen
      logic advance;          // scan happened, seconds may advance
   } idle_ctl_type;

endpackage : keq_pkg

`default_nettype wire

@@ rtl/core/keq_if.sv @@
// keq_if: valid/ready channel interfaces for request and response transactions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface keq_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] enc_count;
   logic [3:0] key_pins;
   logic [7:0] tick_20ms;
   logic [7:0] tick_10ms;
   logic [7:0] sec_tick;

   modport source (output valid, func, enc_count, key_pins, tick_20ms, tick_10ms, sec_tick,
                   input ready);
   modport sink   (input valid, func, enc_count, key_pins, tick_20ms, tick_10ms, sec_tick,
                   output ready);
endinterface : keq_req_if

interface keq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] key_code;
   logic [1:0] enc_dir;
   logic [7:0] enc_steps;
   logic       reload_counter;
   logic [7:0] repeats;
   logic [5:0] idle_seconds;
   logic [5:0] idle_minutes;
   logic [7:0] idle_hours;

   modport source (output valid, key_code, enc_dir, enc_steps, reload_counter, repeats,
                   idle_seconds, idle_minutes, idle_hours,
                   input ready);
   modport sink   (input valid, key_code, enc_dir, enc_steps, reload_counter, repeats,
                   idle_seconds, idle_minutes, idle_hours,
                   output ready);
endinterface : keq_rsp_if

`default_nettype wire

@@ rtl/core/keq_enc.sv @@
// keq_enc: encoder capture and poll handling, decides whether a key scan runs.
// Depends on keq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module keq_enc (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 step,
   input  wire                 func,
   input  wire [7:0]           enc_count,
   input  wire [7:0]           tick_20ms,
   input  wire [7:0]           tick_10ms,
   input  wire [7:0]           enc_low_limit,
   input  wire [7:0]           enc_high_limit,
   input  wire [7:0]           enc_center,
   output keq_pkg::enc_res_type res
);

   logic [7:0] enc_code_ff, enc_code_in;
   logic [7:0] enc_prev_ff, enc_prev_in;
   logic       enc_pending_ff, enc_pending_in;
   logic [7:0] last_enc_tick_ff, last_enc_tick_in;
   logic [7:0] last_scan_tick_ff, last_scan_tick_in;

   always_comb begin
      logic                 do_scan;
      keq_pkg::enc_dir_type d;
      logic [7:0]           s;

      enc_code_in       = enc_code_ff;
      enc_prev_in       = enc_prev_ff;
      enc_pending_in    = enc_pending_ff;
      last_enc_tick_in  = last_enc_tick_ff;
      last_scan_tick_in = last_scan_tick_ff;
      res               = '0;
      res.dir           = keq_pkg::DIR_NONE;
      do_scan           = 1'b1;
      d                 = keq_pkg::DIR_NONE;
      s                 = 8'd0;

      if (func == keq_pkg::FuncCapture) begin
         do_scan        = 1'b0;
         enc_pending_in = 1'b1;
         if (enc_count > enc_high_limit || enc_count < enc_low_limit) begin
            enc_code_in = enc_center;
            enc_prev_in = enc_center;
            res.reload  = 1'b1;
         end else begin
            enc_code_in = enc_count;
         end
      end else begin
         if (enc_pending_ff) begin
            enc_pending_in = 1'b0;
            if (enc_code_ff > enc_prev_ff) begin
               d = keq_pkg::DIR_UP;
               s = enc_code_ff - enc_prev_ff;
            end else if (enc_code_ff < enc_prev_ff) begin
               d = keq_pkg::DIR_DOWN;
               s = enc_prev_ff - enc_code_ff;
            end else begin
               do_scan = 1'b0;
            end
            if (d != keq_pkg::DIR_NONE) begin
               enc_prev_in = enc_code_ff;
               if (last_enc_tick_ff != tick_10ms) begin
                  // at most one report per 10 ms tick
                  enc_code_in      = enc_center;
                  enc_prev_in      = enc_center;
                  last_enc_tick_in = tick_10ms;
                  res.dir          = d;
                  res.steps        = s;
                  res.reload       = 1'b1;
                  res.enc_act      = 1'b1;
                  do_scan          = 1'b0;
               end
            end
         end
         if (do_scan && tick_20ms != last_scan_tick_ff) begin
            last_scan_tick_in = tick_20ms;
            res.scan          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_code_ff       <= keq_pkg::EncCenterReset;
         enc_prev_ff       <= keq_pkg::EncCenterReset;
         enc_pending_ff    <= 1'b0;
         last_enc_tick_ff  <= 8'd0;
         last_scan_tick_ff <= 8'd0;
      end else if (step) begin
         enc_code_ff       <= enc_code_in;
         enc_prev_ff       <= enc_prev_in;
         enc_pending_ff    <= enc_pending_in;
         last_enc_tick_ff  <= last_enc_tick_in;
         last_scan_tick_ff <= last_scan_tick_in;
      end
   end

endmodule : keq_enc

`default_nettype wire

@@ rtl/core/keq_keyscan.sv @@
// keq_keyscan: single-key qualification, confirm and auto-repeat counters.
// Depends on keq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module keq_keyscan (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step,
   input  wire                   scan,
   input  wire [3:0]             key_pins,
   input  wire [7:0]             press_scans,
   input  wire [7:0]             repeat_scans,
   output logic [2:0]            key_code,
   output logic [7:0]            repeats,
   output keq_pkg::idle_ctl_type idle_ctl
);

   logic [2:0] held_key_ff, held_key_in;
   logic [7:0] press_ctr_ff, press_ctr_in;
   logic [7:0] confirm_ctr_ff, confirm_ctr_in;
   logic [7:0] repeat_ctr_ff, repeat_ctr_in;

   always_comb begin
      logic [3:0] pressed;
      logic [2:0] cnt;
      logic [2:0] key;
      logic [7:0] press_inc;
      logic [7:0] confirm_inc;

      pressed     = ~key_pins;
      cnt         = 3'($countones(pressed));
      press_inc   = press_ctr_ff + 8'd1;
      confirm_inc = confirm_ctr_ff + 8'd1;

      // lowest pressed key wins
      priority if (pressed[0]) key = 3'd1;
      else if (pressed[1])     key = 3'd2;
      else if (pressed[2])     key = 3'd3;
      else if (pressed[3])     key = 3'd4;
      else                     key = 3'd0;

      held_key_in      = held_key_ff;
      press_ctr_in     = press_ctr_ff;
      confirm_ctr_in   = confirm_ctr_ff;
      repeat_ctr_in    = repeat_ctr_ff;
      key_code         = 3'd0;
      idle_ctl.advance = scan;
      idle_ctl.clear   = scan && (key_pins != keq_pkg::KeysReleased);

      if (scan) begin
         if (cnt != 3'd1) begin
            held_key_in    = 3'd0;
            press_ctr_in   = 8'd0;
            confirm_ctr_in = 8'd0;
            repeat_ctr_in  = 8'd0;
         end else if (held_key_ff != key) begin
            held_key_in    = key;
            press_ctr_in   = 8'd0;
            confirm_ctr_in = 8'd0;
            repeat_ctr_in  = 8'd0;
         end else if (press_inc >= press_scans) begin
            press_ctr_in = 8'd0;
            if (confirm_ctr_ff != 8'd0) begin
               if (confirm_inc == repeat_scans) begin
                  confirm_ctr_in = 8'd1;
                  repeat_ctr_in  = repeat_ctr_ff + 8'd1;
                  key_code       = key;
               end else begin
                  confirm_ctr_in = confirm_inc;
               end
            end else begin
               // first confirmation
               confirm_ctr_in = 8'd1;
               key_code       = key;
            end
         end else begin
            press_ctr_in = press_inc;
         end
      end

      repeats = repeat_ctr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_key_ff    <= 3'd0;
         press_ctr_ff   <= 8'd0;
         confirm_ctr_ff <= 8'd0;
         repeat_ctr_ff  <= 8'd0;
      end else if (step) begin
         held_key_ff    <= held_key_in;
         press_ctr_ff   <= press_ctr_in;
         confirm_ctr_ff <= confirm_ctr_in;
         repeat_ctr_ff  <= repeat_ctr_in;
      end
   end

endmodule : keq_keyscan

`default_nettype wire

@@ rtl/core/keq_idle.sv @@
// keq_idle: idle timer in seconds, minutes and hours, cleared on input activity.
// Depends on keq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module keq_idle (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step,
   input  wire                   enc_act,
   input  keq_pkg::idle_ctl_type idle_ctl,
   input  wire [7:0]             sec_tick,
   output logic [5:0]            idle_seconds,
   output logic [5:0]            idle_minutes,
   output logic [7:0]            idle_hours
);

   logic [7:0] last_sec_ff, last_sec_in;
   logic       sec_latch_ff, sec_latch_in;
   logic [5:0] idle_sec_ff, idle_sec_in;
   logic [5:0] idle_min_ff, idle_min_in;
   logic [7:0] idle_hour_ff, idle_hour_in;

   always_comb begin
      logic clear;

      clear        = enc_act || idle_ctl.clear;
      last_sec_in  = last_sec_ff;
      sec_latch_in = sec_latch_ff;
      idle_sec_in  = clear ? 6'd0 : idle_sec_ff;
      idle_min_in  = clear ? 6'd0 : idle_min_ff;
      idle_hour_in = clear ? 8'd0 : idle_hour_ff;

      if (idle_ctl.advance) begin
         if (last_sec_ff != sec_tick) begin
            if (!sec_latch_ff) begin
               sec_latch_in = 1'b1;
               last_sec_in  = sec_tick;
               if (idle_sec_in == keq_pkg::SecMinLast) begin
                  idle_sec_in = 6'd0;
                  if (idle_min_in == keq_pkg::SecMinLast) begin
                     idle_min_in  = 6'd0;
                     idle_hour_in = idle_hour_in + 8'd1;
                  end else begin
                     idle_min_in = idle_min_in + 6'd1;
                  end
               end else begin
                  idle_sec_in = idle_sec_in + 6'd1;
               end
            end
         end else begin
            sec_latch_in = 1'b0;
         end
      end

      idle_seconds = idle_sec_in;
      idle_minutes = idle_min_in;
      idle_hours   = idle_hour_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sec_ff  <= 8'd0;
         sec_latch_ff <= 1'b0;
         idle_sec_ff  <= 6'd0;
         idle_min_ff  <= 6'd0;
         idle_hour_ff <= 8'd0;
      end else if (step) begin
         last_sec_ff  <= last_sec_in;
         sec_latch_ff <= sec_latch_in;
         idle_sec_ff  <= idle_sec_in;
         idle_min_ff  <= idle_min_in;
         idle_hour_ff <= idle_hour_in;
      end
   end

endmodule : keq_idle

`default_nettype wire

@@ rtl/core/key_encoder_qualifier.sv @@
// key_encoder_qualifier: top level of the key and encoder qualifier.
// Pipeline: an accepted request is held in the input register, then its response in the result register.
// Throughput: one transaction per cycle; the only limit is response backpressure.
// Reset: synchronous, active high; clears both stage valids, all qualifier state,
// and loads the configuration registers with their defaults. No clearing pass.
// Depends on keq_pkg, keq_if, keq_enc, keq_keyscan, keq_idle.
`timescale 1ns / 1ps
`default_nettype none

module key_encoder_qualifier (
   input  wire                                  clock,
   input  wire                                  reset,
   keq_req_if.sink                              req_ch,
   keq_rsp_if.source                            rsp_ch,
   input  wire                                  csr_we,
   input  wire [keq_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire [keq_pkg::CsrDataWidth-1:0]      csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers; writes to unused indexes are dropped.
   // ---------------------------------------------------------------------
   logic [7:0] press_scans_ff;
   logic [7:0] repeat_scans_ff;
   logic [7:0] enc_low_limit_ff;
   logic [7:0] enc_high_limit_ff;
   logic [7:0] enc_center_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_scans_ff    <= keq_pkg::PressScansReset;
         repeat_scans_ff   <= keq_pkg::RepeatScansReset;
         enc_low_limit_ff  <= keq_pkg::EncLowLimitReset;
         enc_high_limit_ff <= keq_pkg::EncHighLimitReset;
         enc_center_ff     <= keq_pkg::EncCenterReset;
      end else if (csr_we) begin
         unique case (keq_pkg::csr_index_type'(csr_index))
            keq_pkg::CSR_PRESS_SCANS:    press_scans_ff    <= csr_wdata;
            keq_pkg::CSR_REPEAT_SCANS:   repeat_scans_ff   <= csr_wdata;
            keq_pkg::CSR_ENC_LOW_LIMIT:  enc_low_limit_ff  <= csr_wdata;
            keq_pkg::CSR_ENC_HIGH_LIMIT: enc_high_limit_ff <= csr_wdata;
            keq_pkg::CSR_ENC_CENTER:     enc_center_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register. It refills in the same cycle it hands its
   // transaction on, so back-to-back requests flow without bubbles.
   // ---------------------------------------------------------------------
   logic       in_valid_ff;
   logic       in_func_ff;
   logic [7:0] in_enc_count_ff;
   logic [3:0] in_key_pins_ff;
   logic [7:0] in_tick_20ms_ff;
   logic [7:0] in_tick_10ms_ff;
   logic [7:0] in_sec_tick_ff;

   logic out_valid_ff;
   logic step;     // the held transaction is processed and state commits

   assign step         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_func_ff      <= req_ch.func;
         in_enc_count_ff <= req_ch.enc_count;
         in_key_pins_ff  <= req_ch.key_pins;
         in_tick_20ms_ff <= req_ch.tick_20ms;
         in_tick_10ms_ff <= req_ch.tick_10ms;
         in_sec_tick_ff  <= req_ch.sec_tick;
      end
   end

   // ---------------------------------------------------------------------
   // Single pass: encoder decision, then key scan and idle timer.
   // All three commit their state on step.
   // ---------------------------------------------------------------------
   keq_pkg::enc_res_type  enc_res;
   keq_pkg::idle_ctl_type idle_ctl;
   logic [2:0]            key_code;
   logic [7:0]            repeats;
   logic [5:0]            idle_seconds;
   logic [5:0]            idle_minutes;
   logic [7:0]            idle_hours;

   keq_enc u_enc (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .func           (in_func_ff),
      .enc_count      (in_enc_count_ff),
      .tick_20ms      (in_tick_20ms_ff),
      .tick_10ms      (in_tick_10ms_ff),
      .enc_low_limit  (enc_low_limit_ff),
      .enc_high_limit (enc_high_limit_ff),
      .enc_center     (enc_center_ff),
      .res            (enc_res)
   );

   keq_keyscan u_keyscan (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .scan         (enc_res.scan),
      .key_pins     (in_key_pins_ff),
      .press_scans  (press_scans_ff),
      .repeat_scans (repeat_scans_ff),
      .key_code     (key_code),
      .repeats      (repeats),
      .idle_ctl     (idle_ctl)
   );

   keq_idle u_idle (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .enc_act      (enc_res.enc_act),
      .idle_ctl     (idle_ctl),
      .sec_tick     (in_sec_tick_ff),
      .idle_seconds (idle_seconds),
      .idle_minutes (idle_minutes),
      .idle_hours   (idle_hours)
   );

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic [2:0] out_key_code_ff;
   logic [1:0] out_enc_dir_ff;
   logic [7:0] out_enc_steps_ff;
   logic       out_reload_ff;
   logic [7:0] out_repeats_ff;
   logic [5:0] out_idle_sec_ff;
   logic [5:0] out_idle_min_ff;
   logic [7:0] out_idle_hour_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_key_code_ff  <= key_code;
         out_enc_dir_ff   <= enc_res.dir;
         out_enc_steps_ff <= enc_res.steps;
         out_reload_ff    <= enc_res.reload;
         out_repeats_ff   <= repeats;
         out_idle_sec_ff  <= idle_seconds;
         out_idle_min_ff  <= idle_minutes;
         out_idle_hour_ff <= idle_hours;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.key_code       = out_key_code_ff;
   assign rsp_ch.enc_dir        = out_enc_dir_ff;
   assign rsp_ch.enc_steps      = out_enc_steps_ff;
   assign rsp_ch.reload_counter = out_reload_ff;
   assign rsp_ch.repeats        = out_repeats_ff;
   assign rsp_ch.idle_seconds   = out_idle_sec_ff;
   assign rsp_ch.idle_minutes   = out_idle_min_ff;
   assign rsp_ch.idle_hours     = out_idle_hour_ff;

endmodule : key_encoder_qualifier

`default_nettype wire

@@ rtl/core/keq_checker.sv @@
// keq_checker: port-level checks on the response channel, bound to the top level.
// Depends on key_encoder_qualifier and keq_if.
`timescale 1ns / 1ps
`default_nettype none

module keq_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [2:0] key_code,
   input wire [1:0] enc_dir,
   input wire [7:0] enc_steps,
   input wire       reload_counter,
   input wire [5:0] idle_seconds,
   input wire [5:0] idle_minutes,
   input wire [7:0] idle_hours
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(key_code) && $stable(enc_dir)
         && $stable(enc_steps) && $stable(idle_seconds))
      else $error("stalled response changed");

   // an encoder report always asks for a reload, carries steps, excludes a key and clears the idle timer
   a_enc_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && enc_dir != 2'd0 |-> reload_counter && enc_steps != 8'd0
         && key_code == 3'd0 && idle_seconds == 6'd0 && idle_minutes == 6'd0
         && idle_hours == 8'd0)
      else $error("inconsistent encoder report");

   // no direction means no step count
   a_no_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && enc_dir == 2'd0 |-> enc_steps == 8'd0)
      else $error("steps without direction");

   // a key report follows a scan that cleared the idle timer
   a_key_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && key_code != 3'd0 |-> idle_seconds <= 6'd1 && idle_minutes == 6'd0
         && idle_hours == 8'd0 && !reload_counter)
      else $error("key report without idle clear");

   // legal field ranges
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> key_code <= 3'd4 && enc_dir != 2'd3 && idle_seconds < 6'd60
         && idle_minutes < 6'd60)
      else $error("response field out of range");

endmodule : keq_checker

bind key_encoder_qualifier keq_checker u_keq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .key_code       (rsp_ch.key_code),
   .enc_dir        (rsp_ch.enc_dir),
   .enc_steps      (rsp_ch.enc_steps),
   .reload_counter (rsp_ch.reload_counter),
   .idle_seconds   (rsp_ch.idle_seconds),
   .idle_minutes   (rsp_ch.idle_minutes),
   .idle_hours     (rsp_ch.idle_hours)
);

`default_nettype wire

@@ dv/tb_key_encoder_qualifier.sv @@
`timescale 1ns / 1ps
// tb_key_encoder_qualifier: self-checking bench for the key and encoder qualifier.
// Drives captures and polls through keq_req_if, checks keq_rsp_if against a local predictor.
// Depends on keq_pkg, keq_if and the key_encoder_qualifier RTL.

module tb_key_encoder_qualifier;
   import keq_pkg::*;

   // one request transaction, as the bench builds it
   typedef struct packed {
      logic       func;
      logic [7:0] enc_count;
      logic [3:0] key_pins;
      logic [7:0] tick_20ms;
      logic [7:0] tick_10ms;
      logic [7:0] sec_tick;
   } key_req_t;

   // one response transaction
   typedef struct packed {
      logic [2:0]  key_code;
      enc_dir_type enc_dir;
      logic [7:0]  enc_steps;
      logic        reload_counter;
      logic [7:0]  repeats;
      logic [5:0]  idle_seconds;
      logic [5:0]  idle_minutes;
      logic [7:0]  idle_hours;
   } key_rsp_t;

   // index past the register file; the block must ignore writes to it
   localparam logic [CsrIndexWidth-1:0] CsrNoReg = 3'd5;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   keq_req_if req_ch ();
   keq_rsp_if rsp_ch ();

   key_encoder_qualifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: configuration copy plus the qualifier's own state
   // ------------------------------------------------------------------
   logic [7:0] cfg_press, cfg_repeat, cfg_low, cfg_high, cfg_center;
   logic [7:0] enc_cur, enc_ref, enc_tick_seen, scan_tick_seen;
   logic       enc_armed, sec_latched;
   logic [2:0] key_held;
   logic [7:0] press_cnt, confirm_cnt, rep_cnt, sec_seen;
   logic [5:0] idle_s, idle_m;
   logic [7:0] idle_h;

   key_req_t req_backlog[$];     // requests not yet offered to the block
   key_rsp_t predicted_rsp[$];   // responses owed by the block, oldest first

   int n_loaded, n_accepted, n_results, failures;
   int send_gap, send_calm, take_stall, take_calm, take_hold;

   // stimulus tick generators
   logic [7:0] t20_now, t10_now, sec_now;
   logic       sec_flip;

   key_req_t taken;
   key_rsp_t want;
   logic     bad;

   function automatic void clear_idle();
      idle_s = 6'd0;
      idle_m = 6'd0;
      idle_h = 8'd0;
   endfunction

   // Computes the response to one accepted request and advances the state.
   function automatic key_rsp_t qualify_item(key_req_t it);
      key_rsp_t    r;
      logic        scan;
      enc_dir_type d;
      logic [7:0]  s;
      logic [2:0]  hit;
      int          n;
      int          b;
      r.key_code       = 3'd0;
      r.enc_dir        = DIR_NONE;
      r.enc_steps      = 8'd0;
      r.reload_counter = 1'b0;
      scan = (it.func == FuncPoll);
      if (it.func == FuncCapture) begin
         enc_cur   = it.enc_count;
         enc_armed = 1'b1;
         // limits compared as written, even with low above high
         if (enc_cur > cfg_high || enc_cur < cfg_low) begin
            enc_cur          = cfg_center;
            enc_ref          = cfg_center;
            r.reload_counter = 1'b1;
         end
      end else if (enc_armed) begin
         enc_armed = 1'b0;
         d = DIR_NONE;
         s = 8'd0;
         if (enc_cur > enc_ref) begin
            d = DIR_UP;
            s = enc_cur - enc_ref;
         end else if (enc_cur < enc_ref) begin
            d = DIR_DOWN;
            s = enc_ref - enc_cur;
         end else begin
            scan = 1'b0;   // nothing moved: poll ends here
         end
         if (d != DIR_NONE) begin
            enc_ref = enc_cur;
            // one report per 10 ms tick; otherwise fall through to the scan
            if (enc_tick_seen != it.tick_10ms) begin
               enc_cur          = cfg_center;
               enc_ref          = cfg_center;
               clear_idle();
               enc_tick_seen    = it.tick_10ms;
               r.enc_dir        = d;
               r.enc_steps      = s;
               r.reload_counter = 1'b1;
               scan             = 1'b0;
            end
         end
      end
      if (scan && it.tick_20ms != scan_tick_seen) begin
         scan_tick_seen = it.tick_20ms;
         if (it.key_pins != KeysReleased)
            clear_idle();
         if (sec_seen != it.sec_tick) begin
            if (!sec_latched) begin
               sec_latched = 1'b1;
               sec_seen    = it.sec_tick;
               if (idle_s == SecMinLast) begin
                  idle_s = 6'd0;
                  if (idle_m == SecMinLast) begin
                     idle_m = 6'd0;
                     idle_h = idle_h + 8'd1;
                  end else begin
                     idle_m = idle_m + 6'd1;
                  end
               end else begin
                  idle_s = idle_s + 6'd1;
               end
            end
         end else begin
            sec_latched = 1'b0;
         end
         // lowest pressed key wins the code
         n   = 0;
         hit = 3'd0;
         for (b = 4; b >= 1; b--) begin
            if (!it.key_pins[b-1]) begin
               n++;
               hit = 3'(b);
            end
         end
         if (n != 1) begin
            key_held    = 3'd0;
            press_cnt   = 8'd0;
            confirm_cnt = 8'd0;
            rep_cnt     = 8'd0;
         end else if (key_held != hit) begin
            key_held    = hit;
            press_cnt   = 8'd0;
            confirm_cnt = 8'd0;
            rep_cnt     = 8'd0;
         end else begin
            press_cnt = press_cnt + 8'd1;
            if (press_cnt >= cfg_press) begin
               press_cnt = 8'd0;
               if (confirm_cnt == 8'd0) begin
                  confirm_cnt = 8'd1;
                  r.key_code  = hit;
               end else begin
                  confirm_cnt = confirm_cnt + 8'd1;
                  if (confirm_cnt == cfg_repeat) begin
                     confirm_cnt = 8'd1;
                     rep_cnt     = rep_cnt + 8'd1;
                     r.key_code  = hit;
                  end
               end
            end
         end
      end
      r.repeats      = rep_cnt;
      r.idle_seconds = idle_s;
      r.idle_minutes = idle_m;
      r.idle_hours   = idle_h;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: offers queued transactions with random gaps
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken.func      = req_ch.func;
            taken.enc_count = req_ch.enc_count;
            taken.key_pins  = req_ch.key_pins;
            taken.tick_20ms = req_ch.tick_20ms;
            taken.tick_10ms = req_ch.tick_10ms;
            taken.sec_tick  = req_ch.sec_tick;
            predicted_rsp.push_back(qualify_item(taken));
            n_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               taken = req_backlog.pop_front();
               n_loaded++;
               req_ch.valid     <= 1'b1;
               req_ch.func      <= taken.func;
               req_ch.enc_count <= taken.enc_count;
               req_ch.key_pins  <= taken.key_pins;
               req_ch.tick_20ms <= taken.tick_20ms;
               req_ch.tick_10ms <= taken.tick_10ms;
               req_ch.sec_tick  <= taken.sec_tick;
               // occasional back-to-back stretches, otherwise a random idle gap before the next request
               if (send_calm > 0) send_calm--;
               else if ($urandom_range(0, 31) == 0) send_calm = $urandom_range(20, 60);
               send_gap = (send_calm > 0) ? 0 : $urandom_range(0, 5);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: checks each transaction, stalls ready at random
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_stall = 0;
         take_hold  = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_results++;
            if (predicted_rsp.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("[%0t] response %0d with nothing outstanding", $realtime, n_results);
            end else begin
               want = predicted_rsp.pop_front();
               bad  = (rsp_ch.key_code !== want.key_code) ||
                      (rsp_ch.enc_dir !== want.enc_dir) ||
                      (rsp_ch.enc_steps !== want.enc_steps) ||
                      (rsp_ch.reload_counter !== want.reload_counter) ||
                      (rsp_ch.repeats !== want.repeats) ||
                      (rsp_ch.idle_seconds !== want.idle_seconds) ||
                      (rsp_ch.idle_minutes !== want.idle_minutes) ||
                      (rsp_ch.idle_hours !== want.idle_hours);
               if (bad) begin
                  failures++;
                  if (failures <= 10)
                     $display({"[%0t] response %0d mismatch: exp key=%0d dir=%0d steps=%0d ",
                               "reload=%0d rep=%0d idle=%0d:%0d:%0d, got key=%0d dir=%0d ",
                               "steps=%0d reload=%0d rep=%0d idle=%0d:%0d:%0d"},
                              $realtime, n_results, want.key_code, want.enc_dir,
                              want.enc_steps, want.reload_counter, want.repeats,
                              want.idle_hours, want.idle_minutes, want.idle_seconds,
                              rsp_ch.key_code, rsp_ch.enc_dir, rsp_ch.enc_steps,
                              rsp_ch.reload_counter, rsp_ch.repeats, rsp_ch.idle_hours,
                              rsp_ch.idle_minutes, rsp_ch.idle_seconds);
               end
            end
            // long hold-offs: the block fills up and must stall its input
            if (n_results == 60 || n_results == 600)
               take_hold = 200;
            if (take_calm > 0) take_calm--;
            else if ($urandom_range(0, 31) == 0) take_calm = $urandom_range(20, 60);
            take_stall = (take_calm > 0) ? 0 : $urandom_range(0, 5);
         end
         if (take_hold > 0) begin
            take_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (take_stall > 0) begin
            take_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------
   task automatic add_poll(logic [3:0] pins, bit scan, bit fresh10);
      key_req_t it;
      if (scan) begin
         t20_now  = t20_now + 8'($urandom_range(1, 3));
         // alternate moving and repeated second ticks so the idle timer runs
         sec_flip = !sec_flip;
         if (sec_flip)
            sec_now = sec_now + 8'($urandom_range(1, 9));
      end
      if (fresh10)
         t10_now = t10_now + 8'($urandom_range(1, 5));
      it.func      = FuncPoll;
      it.enc_count = 8'($urandom);
      it.key_pins  = pins;
      it.tick_20ms = t20_now;
      it.tick_10ms = t10_now;
      it.sec_tick  = sec_now;
      req_backlog.push_back(it);
   endtask

   task automatic add_capture(logic [7:0] count);
      key_req_t it;
      it.func      = FuncCapture;
      it.enc_count = count;
      it.key_pins  = 4'($urandom);
      it.tick_20ms = 8'($urandom);
      it.tick_10ms = 8'($urandom);
      it.sec_tick  = 8'($urandom);
      req_backlog.push_back(it);
   endtask

   // holds one key for len transactions; dirty holds mix in repeated ticks and captures
   task automatic hold_key(int k, int len, bit clean);
      logic [3:0] pins;
      int         i;
      int         r;
      pins = KeysReleased & ~(4'b0001 << (k - 1));
      for (i = 0; i < len; i++) begin
         r = clean ? 99 : $urandom_range(0, 99);
         if (r < 6) add_poll(pins, 1'b0, 1'b0);
         else if (r < 10) add_capture(8'($urandom));
         else add_poll(pins, 1'b1, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic idle_scans(int len);
      int i;
      for (i = 0; i < len; i++)
         add_poll(KeysReleased, 1'b1, 1'b0);
   endtask

   task automatic run_mix(int budget);
      key_req_t   it;
      logic [7:0] c;
      int         left, pick, len, cap, i;
      left = budget;
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // key hold, now and then long enough to reach auto-repeat
            cap = int'(cfg_press) * (int'(cfg_repeat) + 1) + 3;
            if (cap > 140) cap = 140;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cap) : $urandom_range(1, 12);
            hold_key($urandom_range(1, 4), len, 1'b0);
            left -= len;
         end else if (pick < 60) begin
            // encoder burst: captures near the window edges, then a poll
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++) begin
               case ($urandom_range(0, 7))
                  0: c = cfg_low - 8'd1;
                  1: c = cfg_low;
                  2: c = cfg_high;
                  3: c = cfg_high + 8'd1;
                  4: c = cfg_center + 8'($urandom_range(0, 3));
                  default: c = 8'($urandom);
               endcase
               add_capture(c);
            end
            add_poll(($urandom_range(0, 9) < 7) ? KeysReleased : 4'($urandom), 1'b1,
                     $urandom_range(0, 3) != 0);
            left -= len + 1;
         end else if (pick < 75) begin
            len = $urandom_range(4, 30);
            idle_scans(len);
            left -= len;
         end else if (pick < 88) begin
            // several keys, switching keys, missed scan ticks
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++)
               add_poll(4'($urandom), $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)));
            left -= len;
         end else begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++) begin
               it = key_req_t'({$urandom, $urandom});
               req_backlog.push_back(it);
            end
            left -= len;
         end
      end
   endtask

   // waits until the block has returned everything, plus its pipeline depth
   task automatic drain();
      while (req_backlog.size() != 0 || n_loaded != n_accepted || predicted_rsp.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [7:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_PRESS_SCANS:    cfg_press  = v;
         CSR_REPEAT_SCANS:   cfg_repeat = v;
         CSR_ENC_LOW_LIMIT:  cfg_low    = v;
         CSR_ENC_HIGH_LIMIT: cfg_high   = v;
         CSR_ENC_CENTER:     cfg_center = v;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [7:0] p, logic [7:0] r, logic [7:0] lo, logic [7:0] hi,
                             logic [7:0] c);
      drain();
      write_reg(CSR_PRESS_SCANS, p);
      write_reg(CSR_REPEAT_SCANS, r);
      write_reg(CSR_ENC_LOW_LIMIT, lo);
      write_reg(CSR_ENC_HIGH_LIMIT, hi);
      write_reg(CSR_ENC_CENTER, c);
      write_reg(CsrNoReg, 8'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.func      = FuncPoll;
      req_ch.enc_count = 8'd0;
      req_ch.key_pins  = KeysReleased;
      req_ch.tick_20ms = 8'd0;
      req_ch.tick_10ms = 8'd0;
      req_ch.sec_tick  = 8'd0;
      rsp_ch.ready     = 1'b0;
      n_loaded = 0; n_accepted = 0; n_results = 0; failures = 0;
      send_gap = 0; send_calm = 0; take_stall = 0; take_calm = 0; take_hold = 0;
      t20_now = 8'd0; t10_now = 8'd0; sec_now = 8'd0; sec_flip = 1'b0;

      // predictor after reset
      cfg_press = PressScansReset;  cfg_repeat = RepeatScansReset;
      cfg_low   = EncLowLimitReset; cfg_high   = EncHighLimitReset;
      cfg_center = EncCenterReset;
      enc_cur = EncCenterReset; enc_ref = EncCenterReset; enc_armed = 1'b0;
      enc_tick_seen = 8'd0; scan_tick_seen = 8'd0;
      key_held = 3'd0; press_cnt = 8'd0; confirm_cnt = 8'd0; rep_cnt = 8'd0;
      sec_seen = 8'd0; sec_latched = 1'b0;
      idle_s = 6'd0; idle_m = 6'd0; idle_h = 8'd0;

      // directed part, reset configuration
      add_poll(KeysReleased, 1'b1, 1'b0);   // plain scan, idle second ticks
      add_poll(KeysReleased, 1'b0, 1'b0);   // same 20 ms tick: nothing happens
      add_capture(8'd0);                    // below window: recentre
      add_poll(KeysReleased, 1'b1, 1'b1);   // pending but no movement
      add_capture(8'd255);                  // above window: recentre
      add_capture(8'd5);                    // window edges stay
      add_capture(8'd195);
      add_poll(KeysReleased, 1'b1, 1'b1);   // count rose
      add_capture(8'd10);
      add_poll(KeysReleased, 1'b1, 1'b0);   // same 10 ms tick: scan runs instead
      add_capture(8'd6);
      add_poll(KeysReleased, 1'b1, 1'b1);   // count fell
      add_capture(8'd4);                    // just outside either edge
      add_capture(8'd196);
      add_poll(4'b0000, 1'b1, 1'b0);        // every key pressed
      add_poll(4'b1010, 1'b1, 1'b0);        // two keys
      hold_key(4, 7, 1'b1);                 // key 4 confirmed on the last scan
      add_poll(4'b1110, 1'b1, 1'b0);        // key 1 takes over

      // long quiet stretch rolls the idle seconds into minutes
      idle_scans(125);
      run_mix(180);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // fastest confirm and repeat, window covering all counts
      set_config(8'd1, 8'd2, 8'd0, 8'd255, 8'd0);
      hold_key(2, 270, 1'b0);               // long hold of key 2 keeps the repeat counter climbing
      run_mix(100);

      // slowest confirm, inverted window: every capture recentres
      set_config(8'd255, 8'd255, 8'd255, 8'd0, 8'd255);
      run_mix(80);

      set_config(8'($urandom_range(1, 8)), 8'($urandom_range(2, 6)),
                 8'($urandom_range(0, 120)), 8'($urandom_range(100, 255)), 8'($urandom));
      run_mix(120);

      drain();
      if (failures == 0 && predicted_rsp.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #1000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/keq_pkg.sv
rtl/core/keq_if.sv
rtl/core/keq_enc.sv
rtl/core/keq_keyscan.sv
rtl/core/keq_idle.sv
rtl/core/key_encoder_qualifier.sv
rtl/core/keq_checker.sv
dv/tb_key_encoder_qualifier.sv
